[design/deq_pkg.sv]
package deq_pkg;

   localparam int DEFAULT_DEPTH = 1024;
   localparam int DATA_W        = 32;
   localparam int COUNT_W       = 11;
   localparam int FUNC_W        = 3;

   localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [FUNC_W-1:0] OP_QUERY      = 3'd4;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } deq_state_type;

endpackage

[design/double_ended_queue_unit.sv]
// Channel | Direction | Handshake             | Payload
// req     | in        | req_tvalid/req_tready | tdata: data_in; tuser: func
// rsp     | out       | rsp_tvalid/rsp_tready | tdata: popped/count/front/back; tuser: flags
//
// Pushes, queries, rejected operations and pops that empty the queue load their
// result straight into the output register. A pop that leaves one or more entries
// first passes through ST_READ: the new front or back word is fetched through the
// single RAM port, whose read data is registered; req_tready stays low during the fetch.
// Reset is synchronous, active high; it empties the queue and holds
// req_tready low. RAM contents are not cleared; only held entries are read.
// A waiting result sits in the output register; a new transaction is taken
// when no fetch is pending and that register is free or being drained.
module double_ended_queue_unit import deq_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] data_in
   input  logic [2:0]   req_tuser,   // [2:0] func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // [31:0] popped_value, [42:32] entry_count,
                                     // [74:43] front_value, [106:75] back_value, rest zero
   output logic [3:0]   rsp_tuser    // [0] popped_valid, [1] empty_error,
                                     // [2] full_error, [3] queue_empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   // ring pointers, count and cached end words
   deq_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  front_ff, front_in, back_ff, back_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] front_val_ff, front_val_in, back_val_ff, back_val_in;
   logic              pend_front_ff, pend_front_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] popped_ff, popped_in;
   logic              pvalid_ff, pvalid_in, eerr_ff, eerr_in, ferr_ff, ferr_in;
   logic              qempty_ff, qempty_in;
   logic [COUNT_W-1:0] cnt_out_ff, cnt_out_in;
   logic [DATA_W-1:0] frontv_ff, frontv_in, backv_ff, backv_in;

   // RAM port
   logic              ram_we;
   logic [IDX_W-1:0]  ram_addr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   logic              accept, is_empty, is_full, is_one, need_read;
   logic [FUNC_W-1:0] func;
   logic [DATA_W-1:0] data_in;
   logic [IDX_W-1:0]  front_dec, front_inc, back_dec, back_inc;

   assign func    = req_tuser;
   assign data_in = req_tdata;

   assign req_tready = !reset && (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == FULL_CNT);
   assign is_one   = (count_ff == CNT_W'(1));

   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - IDX_W'(1);
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + IDX_W'(1);
   assign back_dec  = (back_ff == '0) ? LAST_IDX : back_ff - IDX_W'(1);
   assign back_inc  = (back_ff == LAST_IDX) ? '0 : back_ff + IDX_W'(1);

   // pop that leaves one or more entries must fetch the new end word
   assign need_read = ((func == OP_POP_FRONT) || (func == OP_POP_BACK)) && !is_empty && !is_one;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && need_read) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      front_in      = front_ff;
      back_in       = back_ff;
      count_in      = count_ff;
      front_val_in  = front_val_ff;
      back_val_in   = back_val_ff;
      pend_front_in = pend_front_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      popped_in     = popped_ff;
      pvalid_in     = pvalid_ff;
      eerr_in       = eerr_ff;
      ferr_in       = ferr_ff;
      qempty_in     = qempty_ff;
      cnt_out_in    = cnt_out_ff;
      frontv_in     = frontv_ff;
      backv_in      = backv_ff;
      ram_we        = 1'b0;
      ram_addr      = front_ff;
      ram_wdata     = data_in;

      if (state_ff == ST_READ) begin
         if (pend_front_ff) begin
            front_val_in = ram_rdata;
         end else begin
            back_val_in = ram_rdata;
         end
         rsp_valid_in = 1'b1;
         frontv_in    = pend_front_ff ? ram_rdata : front_val_ff;
         backv_in     = pend_front_ff ? back_val_ff : ram_rdata;
      end else if (accept) begin
         popped_in = '0;
         pvalid_in = 1'b0;
         eerr_in   = 1'b0;
         ferr_in   = 1'b0;
         unique case (func)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (is_full) begin
                  ferr_in = 1'b1;
               end else begin
                  ram_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  if (func == OP_PUSH_FRONT) begin
                     ram_addr     = front_dec;
                     front_in     = front_dec;
                     front_val_in = data_in;
                     if (is_empty) begin
                        back_in     = front_dec;
                        back_val_in = data_in;
                     end
                  end else begin
                     ram_addr    = is_empty ? front_ff : back_inc;
                     back_in     = is_empty ? front_ff : back_inc;
                     back_val_in = data_in;
                     if (is_empty) begin
                        front_val_in = data_in;
                     end
                  end
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (is_empty) begin
                  eerr_in = 1'b1;
               end else begin
                  pvalid_in     = 1'b1;
                  count_in      = count_ff - CNT_W'(1);
                  pend_front_in = (func == OP_POP_FRONT);
                  if (func == OP_POP_FRONT) begin
                     popped_in = front_val_ff;
                     front_in  = front_inc;
                     ram_addr  = front_inc;
                  end else begin
                     popped_in = back_val_ff;
                     back_in   = back_dec;
                     ram_addr  = back_dec;
                  end
                  if (is_one) begin
                     front_val_in = '0;
                     back_val_in  = '0;
                  end
               end
            end
            default: ;  // query and unused codes change nothing
         endcase
         cnt_out_in   = COUNT_W'(count_in);
         qempty_in    = (count_in == '0);
         frontv_in    = front_val_in;
         backv_in     = back_val_in;
         rsp_valid_in = !need_read;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         front_ff      <= '0;
         back_ff       <= '0;
         count_ff      <= '0;
         front_val_ff  <= '0;
         back_val_ff   <= '0;
         pend_front_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         back_ff       <= back_in;
         count_ff      <= count_in;
         front_val_ff  <= front_val_in;
         back_val_ff   <= back_val_in;
         pend_front_ff <= pend_front_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      popped_ff  <= popped_in;
      pvalid_ff  <= pvalid_in;
      eerr_ff    <= eerr_in;
      ferr_ff    <= ferr_in;
      qempty_ff  <= qempty_in;
      cnt_out_ff <= cnt_out_in;
      frontv_ff  <= frontv_in;
      backv_ff   <= backv_in;
   end

   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH),
      .ADDR_W(IDX_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, backv_ff, frontv_ff, cnt_out_ff, popped_ff};
   assign rsp_tuser  = {qempty_ff, ferr_ff, eerr_ff, pvalid_ff};

   // count never passes the ring size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above depth");

   // the read state always returns straight to idle
   a_read_short: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_IDLE)
      else $error("read state held too long");

   // no result is raised while a fetch is outstanding
   a_no_rsp_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !rsp_valid_ff)
      else $error("result pending during fetch");

   // an accepted push into a non-full queue grows it by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (func == OP_PUSH_FRONT || func == OP_PUSH_BACK) && !is_full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not grow the queue");

   // an empty queue reports zero end words
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> front_val_ff == '0 && back_val_ff == '0)
      else $error("stale end word in empty queue");

endmodule

[design/deq_ram.sv]
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wr_data,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
